[hdl/swt_pkg.sv]
// Shared types and codes for the segment window tracker.
`timescale 1ns / 1ps

package swt_pkg;

   localparam int MAX_SEGMENTS_DEFAULT = 16;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TICK   = 2'd2
   } swt_kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] position_ms;
      logic [31:0] seg_start_ms;
      logic [31:0] seg_end_ms;
      logic [1:0]  seg_type;
   } swt_req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] hit_start_ms;
      logic [31:0] hit_end_ms;
      logic [1:0]  hit_type;
   } swt_rsp_type;

   // Tick wavefront handed from cell to cell
   typedef struct packed {
      logic        active;
      logic        found;
      logic [31:0] pos;
      logic [31:0] hit_start_ms;
      logic [31:0] hit_end_ms;
      logic [1:0]  hit_type;
   } swt_token_type;

   // Broadcast table control
   typedef struct packed {
      logic clear;
      logic write;
   } swt_ctrl_type;

endpackage

[hdl/segment_window_tracker.sv]
// Top level of the segment window tracker: request decode, cell row and result register.
`timescale 1ns / 1ps

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | req_valid/req_stall | swt_req_type (kind, times)
//  rsp     | out       | rsp_valid/rsp_stall | swt_rsp_type (hit, window)
//
//  Clear and append beats register their result, which is ready the next cycle.
//  A position tick walks the cell row one entry a cycle, through the token register
//  of each cell in turn, and its result is then registered in the result register;
//  no request is taken during the walk.
//  Synchronous active-high reset empties the table, clears every consumed flag
//  and drops any walk in flight. A request is taken while a result waits,
//  unless that result is itself stalled.

module segment_window_tracker #(
   parameter int MAX_SEGMENTS = swt_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  swt_pkg::swt_req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output swt_pkg::swt_rsp_type rsp_payload
);

   localparam int CountWidth = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_SEGMENTS);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  walking_ff, walking_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   swt_pkg::swt_rsp_type  rsp_payload_ff, rsp_payload_in;

   logic                  req_beat;
   logic                  is_tick;
   swt_pkg::swt_ctrl_type ctrl;
   swt_pkg::swt_token_type tokens [MAX_SEGMENTS+1];

   // Hold requests during a walk, or while a stalled result occupies the register
   assign req_stall = walking_ff || (rsp_valid_ff && rsp_stall);
   assign req_beat  = req_valid && !req_stall;
   assign is_tick   = req_payload.kind == swt_pkg::KIND_TICK;

   // Decode table control from the accepted beat
   always_comb begin
      ctrl     = '0;
      count_in = count_ff;
      if (req_beat) begin
         unique case (req_payload.kind)
            swt_pkg::KIND_CLEAR: begin
               ctrl.clear = 1'b1;
               count_in   = '0;
            end
            swt_pkg::KIND_APPEND: begin
               // drop appends to a full table
               if (count_ff < CountMax) begin
                  ctrl.write = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Launch the wavefront into the first cell
   always_comb begin
      tokens[0]        = '0;
      tokens[0].active = req_beat && is_tick;
      tokens[0].pos    = req_payload.position_ms;
   end

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      swt_cell #(
         .CountWidth(CountWidth),
         .Index     (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .count  (count_ff),
         .wr_data(req_payload),
         .tok_in (tokens[i]),
         .tok_out(tokens[i+1])
      );
   end

   // Result register: zero result for non-tick beats, wavefront result at walk end
   always_comb begin
      walking_in     = walking_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (req_beat && is_tick) begin
         walking_in = 1'b1;
      end else if (req_beat) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = '0;
      end
      if (tokens[MAX_SEGMENTS].active) begin
         walking_in                  = 1'b0;
         rsp_valid_in                = 1'b1;
         rsp_payload_in.hit          = tokens[MAX_SEGMENTS].found;
         rsp_payload_in.hit_start_ms = tokens[MAX_SEGMENTS].hit_start_ms;
         rsp_payload_in.hit_end_ms   = tokens[MAX_SEGMENTS].hit_end_ms;
         rsp_payload_in.hit_type     = tokens[MAX_SEGMENTS].hit_type;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         count_ff     <= '0;
         walking_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         walking_ff   <= walking_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[hdl/swt_cell.sv]
// One table entry of the tracker with its slice of the tick wavefront.
`timescale 1ns / 1ps

module swt_cell #(
   parameter int CountWidth = 5,
   parameter int Index      = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  swt_pkg::swt_ctrl_type  ctrl,
   input  logic [CountWidth-1:0]  count,
   input  swt_pkg::swt_req_type   wr_data,
   input  swt_pkg::swt_token_type tok_in,
   output swt_pkg::swt_token_type tok_out
);

   localparam logic [CountWidth-1:0] MyIndex = CountWidth'(Index);

   logic [31:0] start_ff, start_in;
   logic [31:0] end_ff, end_in;
   logic [1:0]  type_ff, type_in;
   logic        consumed_ff, consumed_in;
   swt_pkg::swt_token_type tok_ff, tok_in_next;

   logic in_use;
   logic write_me;
   logic before_start;
   logic before_end;
   logic rearmed;

   assign in_use       = MyIndex < count;
   assign write_me     = ctrl.write && (count == MyIndex);
   assign before_start = tok_in.pos < start_ff;
   assign before_end   = tok_in.pos < end_ff;

   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      type_in     = type_ff;
      consumed_in = consumed_ff;
      tok_in_next = tok_in;
      rearmed     = consumed_ff && !before_start ? 1'b1 : 1'b0;
      if (ctrl.clear) begin
         consumed_in = 1'b0;
      end else if (write_me) begin
         start_in    = wr_data.seg_start_ms;
         end_in      = wr_data.seg_end_ms;
         type_in     = wr_data.seg_type;
         consumed_in = 1'b0;
      end else if (tok_in.active && in_use) begin
         // re-arm when the position lies before the start; rearmed holds still-consumed
         consumed_in = rearmed;
         if (!tok_in.found && !rearmed && !before_start && before_end) begin
            consumed_in              = 1'b1;
            tok_in_next.found        = 1'b1;
            tok_in_next.hit_start_ms = start_ff;
            tok_in_next.hit_end_ms   = end_ff;
            tok_in_next.hit_type     = type_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      type_ff  <= type_in;
      if (reset) begin
         consumed_ff   <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         consumed_ff <= consumed_in;
         tok_ff      <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule
